[rtl/radial_distortion_pixel_remap_macros.svh]
// Assertion helpers for the pixel remap block.
`ifndef RADIAL_DISTORTION_PIXEL_REMAP_MACROS_SVH
`define RADIAL_DISTORTION_PIXEL_REMAP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RDPR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pixel remap check failed");

// Next-cycle implication, checked out of reset.
`define RDPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pixel remap check failed");

`endif

[rtl/rdpr_pkg.sv]
`timescale 1ns / 1ps

package rdpr_pkg;

    // Largest image side accepted as in frame
    localparam int MAX_SIDE_DEF = 4096;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_K_FIRST      = 3'd2,
        CFG_K_SECOND     = 3'd3,
        CFG_FOCAL_X      = 3'd4,
        CFG_FOCAL_Y      = 3'd5,
        CFG_INV_DIST     = 3'd6
    } t_cfg_idx;

    // Reset values
    localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [15:0] RST_K_FIRST      = 16'd410;
    localparam logic [15:0] RST_K_SECOND     = 16'd410;
    localparam logic [11:0] RST_FOCAL_X      = 12'd300;
    localparam logic [11:0] RST_FOCAL_Y      = 12'd300;
    localparam logic [15:0] RST_INV_DIST     = 16'd131;

    // Pipeline depth from request to result strobe
    localparam int NSTG = 11;

endpackage

[rtl/radial_distortion_pixel_remap.sv]
`timescale 1ns / 1ps
`include "radial_distortion_pixel_remap_macros.svh"

// Channel   | Handshake                  | Payload
// ----------+----------------------------+-----------------------------------------
// request   | i_start, o_busy (low)      | i_src_row, i_src_col, i_in_blue/green/red
// result    | o_done (one-cycle strobe)  | o_dest_row, o_dest_col, o_in_frame, colors
// config    | i_cfg_valid, o_cfg_ready   | i_cfg_index, i_cfg_data
//
// Eleven register stages; one request per clock.
// The stage depth is set by the multipliers: squares, radius square, factor,
// offset times factor and offset times focal length each own a stage.
// Reset (synchronous, active low) clears the valid bits and loads the config.
// Nothing stalls: o_busy stays low and the receiver takes every result.
module radial_distortion_pixel_remap
    import rdpr_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [11:0] i_src_row,
    input  logic [11:0] i_src_col,
    input  logic [7:0]  i_in_blue,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_red,
    output logic        o_done,
    output logic [11:0] o_dest_row,
    output logic [11:0] o_dest_col,
    output logic        o_in_frame,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_red,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic signed [44:0] FAC_ONE = 45'sd16777216;
    localparam logic signed [44:0] FAC_MAX = 45'sd2147483647;
    localparam logic signed [44:0] FAC_MIN = -45'sd2147483648;
    localparam logic signed [35:0] MAX_SD  = 36'(MAX_SIDE);

    // Configuration registers
    logic [12:0] r_img_w, r_img_h;
    logic [15:0] r_k_first, r_k_second, r_inv;
    logic [11:0] r_focal_x, r_focal_y;

    logic        acc;
    logic [11:0] cy, cx;

    // Valid bits and pass-through colors
    logic [NSTG-1:0] r_vld, n_vld;
    logic [23:0]     r_pix [NSTG-1];

    // Stage registers
    logic signed [12:0] r_dy, r_dx;
    logic signed [29:0] r_u, r_v;
    logic signed [29:0] r_ud [5];
    logic signed [29:0] r_vd [5];
    logic [56:0]        r_squ, r_sqv;
    logic [30:0]        r_r;
    logic [61:0]        r_r2f;
    logic signed [47:0] r_k1r;
    logic signed [54:0] r_k2r2;
    logic signed [35:0] r_k1t;
    logic signed [31:0] r_fac;
    logic signed [61:0] r_pu, r_pv;
    logic signed [50:0] r_qr, r_qc;
    logic signed [35:0] r_dr, r_dc;

    // Combinational next values
    logic signed [12:0] n_dy, n_dx;
    logic signed [29:0] n_u, n_v;
    logic signed [59:0] w_squ, w_sqv;
    logic [57:0]        w_rsum;
    logic [30:0]        n_r;
    logic signed [47:0] n_k1r;
    logic signed [54:0] n_k2r2;
    logic signed [44:0] w_fsum;
    logic signed [31:0] n_fac;
    logic signed [35:0] n_dr, n_dc;
    logic               n_in_frame;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign acc         = i_start && !o_busy;
    assign cy          = r_img_h[12:1];
    assign cx          = r_img_w[12:1];

    // Write configuration; ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w    <= RST_IMAGE_WIDTH;
            r_img_h    <= RST_IMAGE_HEIGHT;
            r_k_first  <= RST_K_FIRST;
            r_k_second <= RST_K_SECOND;
            r_focal_x  <= RST_FOCAL_X;
            r_focal_y  <= RST_FOCAL_Y;
            r_inv      <= RST_INV_DIST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_img_w    <= i_cfg_data[12:0];
                CFG_IMAGE_HEIGHT: r_img_h    <= i_cfg_data[12:0];
                CFG_K_FIRST:      r_k_first  <= i_cfg_data;
                CFG_K_SECOND:     r_k_second <= i_cfg_data;
                CFG_FOCAL_X:      r_focal_x  <= i_cfg_data[11:0];
                CFG_FOCAL_Y:      r_focal_y  <= i_cfg_data[11:0];
                CFG_INV_DIST:     r_inv      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance valid bits
    assign n_vld = {r_vld[NSTG-2:0], acc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Carry colors along the pipeline
    always_ff @(posedge i_clk) begin
        r_pix[0] <= {i_in_blue, i_in_green, i_in_red};
        for (int i = 1; i < NSTG - 1; i++) begin
            r_pix[i] <= r_pix[i-1];
        end
    end

    // Offsets from the centre, scaled offsets and their squares
    assign n_dy  = $signed({1'b0, i_src_row}) - $signed({1'b0, cy});
    assign n_dx  = $signed({1'b0, i_src_col}) - $signed({1'b0, cx});
    assign n_u   = r_dy * $signed({1'b0, r_inv});
    assign n_v   = r_dx * $signed({1'b0, r_inv});
    assign w_squ = r_u * r_u;
    assign w_sqv = r_v * r_v;

    // Squared radius, saturated to 31 bits
    assign w_rsum = {1'b0, r_squ} + {1'b0, r_sqv};
    assign n_r    = (|w_rsum[57:39]) ? 31'h7FFF_FFFF : w_rsum[38:8];

    // Radial terms and the distortion factor
    assign n_k1r  = $signed(r_k_first) * $signed({1'b0, r_r});
    assign n_k2r2 = $signed(r_k_second) * $signed({1'b0, r_r2f[61:24]});
    assign w_fsum = FAC_ONE + 45'(r_k1t) + 45'($signed(r_k2r2[54:12]));

    always_comb begin
        if (w_fsum > FAC_MAX) begin
            n_fac = 32'sh7FFF_FFFF;
        end else if (w_fsum < FAC_MIN) begin
            n_fac = 32'sh8000_0000;
        end else begin
            n_fac = w_fsum[31:0];
        end
    end

    // Floor back to whole pixels and add the centre
    assign n_dr = 36'($signed(r_qr[50:16])) + 36'($signed({1'b0, cy}));
    assign n_dc = 36'($signed(r_qc[50:16])) + 36'($signed({1'b0, cx}));

    // Frame check on both coordinates
    assign n_in_frame = !r_dr[35] && (r_dr < 36'($signed({1'b0, r_img_h}))) && (r_dr < MAX_SD)
                     && !r_dc[35] && (r_dc < 36'($signed({1'b0, r_img_w}))) && (r_dc < MAX_SD);

    // Datapath stages
    always_ff @(posedge i_clk) begin
        r_dy   <= n_dy;
        r_dx   <= n_dx;
        r_u    <= n_u;
        r_v    <= n_v;
        r_squ  <= w_squ[56:0];
        r_sqv  <= w_sqv[56:0];
        r_r    <= n_r;
        r_r2f  <= r_r * r_r;
        r_k1r  <= n_k1r;
        r_k1t  <= r_k1r[47:12];
        r_k2r2 <= n_k2r2;
        r_fac  <= n_fac;
        r_pu   <= r_ud[4] * r_fac;
        r_pv   <= r_vd[4] * r_fac;
        r_qr   <= $signed(r_pu[61:24]) * $signed({1'b0, r_focal_y});
        r_qc   <= $signed(r_pv[61:24]) * $signed({1'b0, r_focal_x});
        r_dr   <= n_dr;
        r_dc   <= n_dc;
        r_ud[0] <= r_u;
        r_vd[0] <= r_v;
        for (int i = 1; i < 5; i++) begin
            r_ud[i] <= r_ud[i-1];
            r_vd[i] <= r_vd[i-1];
        end
    end

    // Output registers
    always_ff @(posedge i_clk) begin
        o_dest_row  <= r_dr[11:0];
        o_dest_col  <= r_dc[11:0];
        o_in_frame  <= n_in_frame;
        o_out_blue  <= r_pix[NSTG-2][23:16];
        o_out_green <= r_pix[NSTG-2][15:8];
        o_out_red   <= r_pix[NSTG-2][7:0];
    end

    assign o_done = r_vld[NSTG-1];

    // Checks
    `RDPR_ASSERT_IMPL(a_done_follows_req, i_clk, i_rst_n, o_done, $past(acc, NSTG))
    `RDPR_ASSERT_IMPL(a_color_pass, i_clk, i_rst_n, o_done, o_out_blue == $past(i_in_blue, NSTG))
    `RDPR_ASSERT_NEXT(a_neg_row_out, i_clk, i_rst_n, r_vld[NSTG-2] && r_dr[35], !o_in_frame)

endmodule

[dv/radial_distortion_pixel_remap_tb.sv]
`timescale 1ns / 1ps

module radial_distortion_pixel_remap_tb;
    import rdpr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    // Register index that maps to nothing; writes to it must be dropped
    localparam logic [2:0] CFG_IDX_SPARE = 3'd7;

    typedef struct packed {
        logic [11:0] row;
        logic [11:0] col;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } pixel_t;

    typedef struct packed {
        logic [11:0] dest_row;
        logic [11:0] dest_col;
        logic        in_frame;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } remap_t;

    // Raw write data for all seven registers, in index order
    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] k1;
        logic [15:0] k2;
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] inv;
    } lens_setup_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [11:0] i_src_row = '0;
    logic [11:0] i_src_col = '0;
    logic [7:0]  i_in_blue = '0;
    logic [7:0]  i_in_green = '0;
    logic [7:0]  i_in_red = '0;
    logic        o_done;
    logic [11:0] o_dest_row;
    logic [11:0] o_dest_col;
    logic        o_in_frame;
    logic [7:0]  o_out_blue;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_red;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    // Local copy of the lens registers
    logic [12:0]        lens_width  = RST_IMAGE_WIDTH;
    logic [12:0]        lens_height = RST_IMAGE_HEIGHT;
    logic signed [15:0] lens_k1     = RST_K_FIRST;
    logic signed [15:0] lens_k2     = RST_K_SECOND;
    logic [11:0]        lens_fx     = RST_FOCAL_X;
    logic [11:0]        lens_fy     = RST_FOCAL_Y;
    logic [15:0]        lens_inv    = RST_INV_DIST;

    pixel_t pending_pixels[$];
    remap_t expected_remaps[$];
    int     error_count = 0;
    int     cycle_count = 0;
    int     burst_left = 1;
    int     gap_left = 0;

    radial_distortion_pixel_remap dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_src_row   (i_src_row),
        .i_src_col   (i_src_col),
        .i_in_blue   (i_in_blue),
        .i_in_green  (i_in_green),
        .i_in_red    (i_in_red),
        .o_done      (o_done),
        .o_dest_row  (o_dest_row),
        .o_dest_col  (o_dest_col),
        .o_in_frame  (o_in_frame),
        .o_out_blue  (o_out_blue),
        .o_out_green (o_out_green),
        .o_out_red   (o_out_red),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Scale a Q16 offset by the Q24 factor and focal length, add the centre, floor
    function automatic longint project_axis(input longint off, input longint fac,
                                            input longint focal, input longint centre);
        longint p;
        longint q;
        p = (off * fac) >>> 24;
        q = p * focal + centre * 65536;
        return q >>> 16;
    endfunction

    // Forward radial distortion of one pixel under the current lens registers
    function automatic remap_t predict_remap(input pixel_t px);
        longint            cy;
        longint            cx;
        longint            inv;
        longint            k1;
        longint            k2;
        longint            u;
        longint            v;
        longint            radius;
        longint            radius_sq;
        longint            fac;
        longint            dr;
        longint            dc;
        longint unsigned   uu;
        longint unsigned   vv;
        longint unsigned   rsum;
        remap_t            res;
        cy  = lens_height >> 1;
        cx  = lens_width >> 1;
        inv = lens_inv;
        k1  = lens_k1;
        k2  = lens_k2;
        u = (longint'(px.row) - cy) * inv;
        v = (longint'(px.col) - cx) * inv;
        uu = (u < 0) ? -u : u;
        vv = (v < 0) ? -v : v;
        rsum = (uu * uu + vv * vv) >> 8;
        // Saturate the squared radius to 31 bits
        radius = (rsum > 64'd2147483647) ? 64'sd2147483647 : longint'(rsum);
        radius_sq = (radius * radius) >>> 24;
        fac = 64'sd16777216 + ((k1 * radius) >>> 12) + ((k2 * radius_sq) >>> 12);
        if (fac > 64'sd2147483647) fac = 64'sd2147483647;
        if (fac < -64'sd2147483648) fac = -64'sd2147483648;
        dr = project_axis(u, fac, longint'(lens_fy), cy);
        dc = project_axis(v, fac, longint'(lens_fx), cx);
        res.dest_row = dr[11:0];
        res.dest_col = dc[11:0];
        res.in_frame = (dr >= 0) && (dr < longint'(lens_height)) && (dr < MAX_SIDE_DEF)
                    && (dc >= 0) && (dc < longint'(lens_width)) && (dc < MAX_SIDE_DEF);
        res.blue  = px.blue;
        res.green = px.green;
        res.red   = px.red;
        return res;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    task automatic push_pixel(input logic [11:0] row, input logic [11:0] col,
                              input logic [7:0] blue, input logic [7:0] green,
                              input logic [7:0] red);
        pending_pixels.push_back({row, col, blue, green, red});
    endtask

    // Mostly pixels inside the image, the rest anywhere in the 12-bit range
    task automatic push_random_pixels(input int count);
        pixel_t px;
        int     h;
        int     w;
        h = (lens_height > 4096) ? 4096 : lens_height;
        w = (lens_width > 4096) ? 4096 : lens_width;
        repeat (count) begin
            if (h != 0 && w != 0 && $urandom_range(0, 9) < 7) begin
                px.row = 12'($urandom_range(0, h - 1));
                px.col = 12'($urandom_range(0, w - 1));
            end else begin
                px.row = 12'($urandom);
                px.col = 12'($urandom);
            end
            px.blue  = 8'($urandom);
            px.green = 8'($urandom);
            px.red   = 8'($urandom);
            pending_pixels.push_back(px);
        end
    endtask

    // Hold until every pixel is sent and every remap has come back
    task automatic wait_idle();
        while (pending_pixels.size() != 0 || i_start || expected_remaps.size() != 0)
            @(posedge i_clk);
    endtask

    // Raise the write request and hold it until taken; the caller lowers valid
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IMAGE_WIDTH:  lens_width  = data[12:0];
            CFG_IMAGE_HEIGHT: lens_height = data[12:0];
            CFG_K_FIRST:      lens_k1     = data;
            CFG_K_SECOND:     lens_k2     = data;
            CFG_FOCAL_X:      lens_fx     = data[11:0];
            CFG_FOCAL_Y:      lens_fy     = data[11:0];
            CFG_INV_DIST:     lens_inv    = data;
            default: ;
        endcase
    endtask

    task automatic apply_setup(input lens_setup_t s, input bit with_spare);
        write_reg(CFG_IMAGE_WIDTH, s.width);
        write_reg(CFG_IMAGE_HEIGHT, s.height);
        write_reg(CFG_K_FIRST, s.k1);
        write_reg(CFG_K_SECOND, s.k2);
        write_reg(CFG_FOCAL_X, s.fx);
        write_reg(CFG_FOCAL_Y, s.fy);
        write_reg(CFG_INV_DIST, s.inv);
        if (with_spare) write_reg(CFG_IDX_SPARE, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Plausible lens (focal times inverse distance near one) or fully random bits
    function automatic lens_setup_t random_setup(input bit wild);
        lens_setup_t s;
        int          f;
        int          inv;
        if (wild) begin
            s = {$urandom, $urandom, $urandom, 16'($urandom)};
        end else begin
            s.width  = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(4097, 8191)
                                                       : $urandom_range(16, 4096));
            s.height = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(4097, 8191)
                                                       : $urandom_range(16, 4096));
            f = $urandom_range(1, 4095);
            s.fx = 16'(f);
            f = f + $urandom_range(0, f / 2) - f / 4;
            s.fy = 16'((f > 4095) ? 4095 : ((f < 1) ? 1 : f));
            inv = $urandom_range(49152, 81920) / s.fx;
            s.inv = 16'((inv > 65535) ? 65535 : inv);
            s.k1 = 16'($urandom_range(0, 4096) - 2048);
            s.k2 = 16'($urandom_range(0, 2048) - 1024);
        end
        return s;
    endfunction

    // Free-running cycle limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Request driver: bursts of pixels separated by random gaps
    always @(posedge i_clk) begin : pixel_driver
        logic free;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            free = !i_start || !o_busy;
            // Record the prediction for the request taken at this edge
            if (i_start && !o_busy) begin
                expected_remaps.push_back(predict_remap(pending_pixels.pop_front()));
            end
            if (free) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_start <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    i_start    <= 1'b1;
                    i_src_row  <= pending_pixels[0].row;
                    i_src_col  <= pending_pixels[0].col;
                    i_in_blue  <= pending_pixels[0].blue;
                    i_in_green <= pending_pixels[0].green;
                    i_in_red   <= pending_pixels[0].red;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                                 : $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each strobe against the oldest prediction
    always @(posedge i_clk) begin : result_check
        remap_t want;
        if (i_rst_n && o_done) begin
            if (expected_remaps.size() == 0) begin
                flag_error($sformatf("unexpected result row=%0d col=%0d",
                                     o_dest_row, o_dest_col));
            end else begin
                want = expected_remaps.pop_front();
                if (o_dest_row !== want.dest_row || o_dest_col !== want.dest_col
                        || o_in_frame !== want.in_frame || o_out_blue !== want.blue
                        || o_out_green !== want.green || o_out_red !== want.red) begin
                    flag_error($sformatf(
                        "mismatch exp row=%0d col=%0d in=%0b bgr=%h/%h/%h got %0d %0d %0b %h/%h/%h",
                        want.dest_row, want.dest_col, want.in_frame,
                        want.blue, want.green, want.red,
                        o_dest_row, o_dest_col, o_in_frame,
                        o_out_blue, o_out_green, o_out_red));
                end
            end
        end
    end

    initial begin : stimulus
        int n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset lens: corners, centre, frame edges, alternating bit patterns
        push_pixel(12'd0, 12'd0, 8'h00, 8'h00, 8'h00);
        push_pixel(12'd4095, 12'd4095, 8'hff, 8'hff, 8'hff);
        push_pixel(12'd0, 12'd4095, 8'h00, 8'hff, 8'h00);
        push_pixel(12'd4095, 12'd0, 8'hff, 8'h00, 8'hff);
        push_pixel(12'd240, 12'd320, 8'h12, 8'h34, 8'h56);
        push_pixel(12'd239, 12'd319, 8'h01, 8'h80, 8'h7f);
        push_pixel(12'd241, 12'd321, 8'hfe, 8'h7f, 8'h80);
        push_pixel(12'haaa, 12'h555, 8'haa, 8'h55, 8'haa);
        push_pixel(12'h555, 12'haaa, 8'h55, 8'haa, 8'h55);
        push_pixel(12'd479, 12'd639, 8'h11, 8'h22, 8'h33);
        push_pixel(12'd480, 12'd640, 8'h44, 8'h55, 8'h66);
        push_pixel(12'd0, 12'd320, 8'h77, 8'h88, 8'h99);
        push_pixel(12'd240, 12'd0, 8'haa, 8'hbb, 8'hcc);
        push_pixel(12'd479, 12'd0, 8'hdd, 8'hee, 8'hff);
        push_pixel(12'd0, 12'd639, 8'h0f, 8'hf0, 8'h3c);
        push_pixel(12'd2048, 12'd2048, 8'hc3, 8'h5a, 8'ha5);
        push_pixel(12'd100, 12'd600, 8'h96, 8'h69, 8'he1);
        push_pixel(12'd400, 12'd50, 8'h1e, 8'h87, 8'h78);
        push_random_pixels(40);
        wait_idle();

        // Zero-size image; radius and factor saturate high
        apply_setup({16'd0, 16'd0, 16'h7fff, 16'h7fff, 16'd4095, 16'd4095, 16'hffff}, 1'b0);
        push_random_pixels(20);
        wait_idle();

        // Width beyond the side limit; factor saturates low; dropped register write
        apply_setup({16'hffff, 16'd4096, 16'h8000, 16'h8000, 16'd0, 16'd4095, 16'hffff},
                    1'b1);
        push_random_pixels(20);
        wait_idle();

        // One-pixel image, no distortion, zero inverse distance
        apply_setup({16'd1, 16'd1, 16'd0, 16'd0, 16'd4095, 16'd0, 16'd0}, 1'b0);
        push_random_pixels(20);
        wait_idle();

        // Random lenses, every third one with arbitrary register bits
        for (n = 0; n < 6; n++) begin
            apply_setup(random_setup(n % 3 == 2), n == 1);
            push_random_pixels(50);
            wait_idle();
        end

        // Drain window to catch stray strobes
        repeat (NSTG + 4) @(posedge i_clk);
        if (expected_remaps.size() != 0) flag_error("remaps never returned");
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/rdpr_pkg.sv
rtl/radial_distortion_pixel_remap.sv
dv/radial_distortion_pixel_remap_tb.sv
